[src/orb_pkg.sv]
package orb_pkg;

	// default sizing
	localparam int DEPTH_DEF        = 64;
	localparam int ELEMENT_BITS_DEF = 32;

	// field widths fixed by the interface
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// request item
	typedef struct packed {
		logic               req_type;
		logic [DATA_W-1:0]  write_data;
		logic               write_last;
		logic [COUNT_W-1:0] read_count;
	} req_item_t;

	// response item
	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               read_valid;
		logic               read_last;
		logic [COUNT_W-1:0] granted_count;
		logic [DATA_W-1:0]  missed_total;
	} rsp_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic wr;          // write element transfer
		logic rd_start;    // read request taken: latch grant
		logic rd_cur;      // RAM read at current read pointer
		logic rd_next;     // RAM read at advanced read pointer
		logic load_elem;   // load element into output register
		logic load_empty;  // load empty reply into output register
	} orb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic grant_zero;     // request on the port grants nothing
		logic remaining_one;  // element being loaded is the last
		logic out_free;       // output register can take a new item
	} orb_sts_t;

endpackage

[src/orb_ram.sv]
module orb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/orb_ctrl.sv]
module orb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_type,
	output logic               req_ready,
	input  orb_pkg::orb_sts_t  sts,
	output orb_pkg::orb_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_DATA  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type == orb_pkg::REQ_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.rd_start = 1'b1;
						if (sts.grant_zero) begin
							state_d = ST_EMPTY;
						end else begin
							cmd.rd_cur = 1'b1;
							state_d    = ST_DATA;
						end
					end
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.load_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_DATA: begin
				// stream: load one element, fetch the next in the same cycle
				if (sts.out_free) begin
					cmd.load_elem = 1'b1;
					if (sts.remaining_one) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/orb_dpath.sv]
module orb_dpath #(
	parameter int DEPTH        = orb_pkg::DEPTH_DEF,
	parameter int ELEMENT_BITS = orb_pkg::ELEMENT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  orb_pkg::req_item_t           req,
	input  logic                         cfg_we,
	input  logic [orb_pkg::COUNT_W-1:0]  cfg_data,
	input  orb_pkg::orb_cmd_t            cmd,
	output orb_pkg::orb_sts_t            sts,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output orb_pkg::rsp_item_t           rsp
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int CMP_W = (CNT_W > orb_pkg::COUNT_W) ? CNT_W : orb_pkg::COUNT_W;
	localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;
	localparam int EXT_W = ELEMENT_BITS + orb_pkg::DATA_W;

	logic [PTR_W-1:0]            wptr_q;
	logic [PTR_W-1:0]            rptr_q;
	logic [CNT_W-1:0]            cap_q;
	logic [CNT_W-1:0]            free_q;
	logic [CNT_W-1:0]            burst_q;
	logic [orb_pkg::DATA_W-1:0]  missed_q;
	logic [orb_pkg::COUNT_W-1:0] remaining_q;
	logic [orb_pkg::COUNT_W-1:0] granted_q;
	logic                        out_valid_q;
	orb_pkg::rsp_item_t          out_q;

	logic [PTR_W-1:0]            wptr_adv;
	logic [PTR_W-1:0]            rptr_adv;
	logic [CNT_W-1:0]            unread;
	logic [CMP_W-1:0]            want_w;
	logic [CMP_W-1:0]            unread_w;
	logic [CMP_W-1:0]            grant_w;
	logic [orb_pkg::COUNT_W-1:0] grant;
	logic                        store_el;
	logic [CNT_W-1:0]            cap_new;
	logic [EXT_W-1:0]            wext;
	logic [EXT_W-1:0]            rext;
	logic [ELEMENT_BITS-1:0]     ram_rdata;
	logic                        out_free;

	// step a pointer round the ring in use
	function automatic logic [PTR_W-1:0] advance(
		input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] cap
	);
		logic [CNT_W-1:0] nxt;
		nxt = {1'b0, p} + CNT_W'(1);
		return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
	endfunction

	assign wptr_adv = advance(wptr_q, cap_q);
	assign rptr_adv = advance(rptr_q, cap_q);

	// grant = min(read_count, unread)
	assign unread   = cap_q - free_q;
	assign want_w   = CMP_W'(req.read_count);
	assign unread_w = CMP_W'(unread);
	assign grant_w  = (want_w < unread_w) ? want_w : unread_w;
	assign grant    = grant_w[orb_pkg::COUNT_W-1:0];

	// elements past the capacity within one burst are dropped
	assign store_el = cmd.wr && (burst_q < cap_q);

	// capacity clamp to 1..DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			cap_new = CNT_W'(1);
		end else if (32'(cfg_data) > DEPTH) begin
			cap_new = CNT_W'(DEPTH);
		end else begin
			cap_new = CNT_W'(cfg_data);
		end
	end

	// element width conversions
	assign wext = {{ELEMENT_BITS{1'b0}}, req.write_data};
	assign rext = {{orb_pkg::DATA_W{1'b0}}, ram_rdata};

	orb_ram #(
		.WIDTH (ELEMENT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (store_el),
		.waddr (wptr_q),
		.wdata (wext[ELEMENT_BITS-1:0]),
		.re    (cmd.rd_cur | cmd.rd_next),
		.raddr (cmd.rd_next ? rptr_adv : rptr_q),
		.rdata (ram_rdata)
	);

	// ring pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			cap_q    <= CNT_W'(CAP_RST);
			free_q   <= CNT_W'(CAP_RST);
			burst_q  <= '0;
			missed_q <= '0;
		end else if (cfg_we) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			cap_q   <= cap_new;
			free_q  <= cap_new;
			burst_q <= '0;
		end else begin
			if (store_el) begin
				wptr_q <= wptr_adv;
				if (free_q != '0) begin
					free_q <= free_q - CNT_W'(1);
				end else begin
					// full: oldest element lost, read side follows the write side
					missed_q <= missed_q + 32'd1;
					rptr_q   <= wptr_adv;
				end
			end
			if (cmd.wr) begin
				if (req.write_last) begin
					burst_q <= '0;
				end else if (store_el) begin
					burst_q <= burst_q + CNT_W'(1);
				end
			end
			if (cmd.load_elem) begin
				rptr_q <= rptr_adv;
				free_q <= free_q + CNT_W'(1);
			end
		end
	end

	// read request bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			granted_q   <= '0;
		end else if (cmd.rd_start) begin
			remaining_q <= grant;
			granted_q   <= grant;
		end else if (cmd.load_elem) begin
			remaining_q <= remaining_q - orb_pkg::COUNT_W'(1);
		end
	end

	// output register
	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_elem || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_elem) begin
			out_q.read_data     <= rext[orb_pkg::DATA_W-1:0];
			out_q.read_valid    <= 1'b1;
			out_q.read_last     <= (remaining_q == orb_pkg::COUNT_W'(1));
			out_q.granted_count <= granted_q;
			out_q.missed_total  <= missed_q;
		end else if (cmd.load_empty) begin
			out_q.read_data     <= '0;
			out_q.read_valid    <= 1'b0;
			out_q.read_last     <= 1'b1;
			out_q.granted_count <= '0;
			out_q.missed_total  <= missed_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign sts.grant_zero    = (grant == '0);
	assign sts.remaining_one = (remaining_q == orb_pkg::COUNT_W'(1));
	assign sts.out_free      = out_free;

endmodule

[src/overwriting_ring_buffer_core.sv]
// Write element: taken while the port is idle, one element per cycle back to back.
// Read request: first element goes through the registered RAM read into the output
// register, then one element per cycle while the output is taken; a read of N
// elements keeps the request port busy until its last element is loaded.
// Empty read: one empty reply, port busy until it is loaded. Reset (asynchronous,
// active low) empties the ring, capacity min(DEPTH, 64); store not cleared.
module overwriting_ring_buffer_core #(
	parameter int DEPTH        = orb_pkg::DEPTH_DEF,
	parameter int ELEMENT_BITS = orb_pkg::ELEMENT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  orb_pkg::req_item_t          req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output orb_pkg::rsp_item_t          rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [orb_pkg::COUNT_W-1:0] cfg_data
);

	orb_pkg::orb_cmd_t cmd;
	orb_pkg::orb_sts_t sts;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	orb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	orb_dpath #(
		.DEPTH        (DEPTH),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
